// ===== src/depth_hole_median_fill_core_macros.svh =====
// ----------------------------------------------------------------------------
// Depth hole median fill - assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_HOLE_MEDIAN_FILL_CORE_MACROS_SVH
`define DEPTH_HOLE_MEDIAN_FILL_CORE_MACROS_SVH

// same-cycle implication
`define DHMF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DHMF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dhmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - package
// Shared types, register indexes, reset values and sorting helpers.
// ----------------------------------------------------------------------------
package dhmf_pkg;

   localparam int DEPTH_BITS    = 32;
   localparam int MAX_WIDTH_DEF = 4096;
   localparam int POS_LIMIT     = 4096;
   localparam int CW            = 12;   // column / line position
   localparam int RW            = 13;   // input line count, size registers
   localparam int CSR_W         = 32;
   localparam int Q_DEPTH       = 4;    // power of two
   localparam int QPW           = $clog2(Q_DEPTH);
   localparam int QCW           = $clog2(Q_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_IMG_WIDTH  = 3'd0,
      REG_IMG_HEIGHT = 3'd1,
      REG_NEAR       = 3'd2,
      REG_FAR        = 3'd3,
      REG_ALPHA      = 3'd4
   } csr_idx_type;

   localparam logic [RW-1:0]         RST_WIDTH  = 13'd640;
   localparam logic [RW-1:0]         RST_HEIGHT = 13'd480;
   localparam logic [DEPTH_BITS-1:0] RST_NEAR   = 32'd655;
   localparam logic [DEPTH_BITS-1:0] RST_FAR    = 32'd6553600;
   localparam logic [15:0]           RST_ALPHA  = 16'd62259;

   typedef logic [DEPTH_BITS-1:0] depth_type;

   typedef struct packed {
      logic      cov;
      logic      rel;
      depth_type depth;
   } px_type;

   // index 0 top, 1 middle, 2 bottom
   typedef px_type [2:0] pcol_type;

   // msb set marks an unused slot so it sorts last
   typedef logic [DEPTH_BITS:0] key_type;
   typedef key_type [7:0] key_arr_type;

   typedef struct packed {
      logic [RW-1:0] width;
      logic [RW-1:0] height;
      depth_type     near;
      depth_type     far;
      logic [15:0]   alpha;
   } cfg_type;

   typedef struct packed {
      logic [CW-1:0] pos_x;
      logic [CW-1:0] pos_y;
      logic          last;
      logic          hole;
      key_arr_type   keys;
   } win_item_type;

   typedef struct packed {
      logic [CW-1:0] pos_x;
      logic [CW-1:0] pos_y;
      logic          last;
      logic          hole;
      logic [3:0]    cnt;
      key_arr_type   keys;
   } bk_item_type;

   function automatic key_arr_type csw(key_arr_type k, int a, int b);
      key_type     t;
      key_arr_type r;
      r = k;
      if (r[a] > r[b]) begin
         t    = r[a];
         r[a] = r[b];
         r[b] = t;
      end
      return r;
   endfunction

   // odd-even merge sort, 8 inputs, 6 layers
   function automatic key_arr_type sort_layer(key_arr_type k, logic [2:0] layer);
      key_arr_type r;
      case (layer)
         3'd0: r = csw(csw(csw(csw(k, 0, 1), 2, 3), 4, 5), 6, 7);
         3'd1: r = csw(csw(csw(csw(k, 0, 2), 1, 3), 4, 6), 5, 7);
         3'd2: r = csw(csw(k, 1, 2), 5, 6);
         3'd3: r = csw(csw(csw(csw(k, 0, 4), 1, 5), 2, 6), 3, 7);
         3'd4: r = csw(csw(k, 2, 4), 3, 5);
         3'd5: r = csw(csw(csw(k, 1, 2), 3, 4), 5, 6);
         default: r = k;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] count_valid(key_arr_type k);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + 4'(~k[i][DEPTH_BITS]);
      end
      return c;
   endfunction

endpackage

// ===== src/dhmf_ram.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dhmf_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/dhmf_front.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - front end
// Classifies pixels, runs the two line stores and the 3x3 window, and emits
// one masked neighbor set per reported pixel.
// ----------------------------------------------------------------------------
module dhmf_front import dhmf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          restart,
   input  logic          accept,
   input  depth_type     depth_value,
   input  logic          depth_finite,
   input  logic [15:0]   opacity,
   input  logic          covered,
   input  logic          flush,
   output logic          push,
   output win_item_type  push_item,
   output logic          busy
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_row_ff, out_row_in;

   logic [RW-1:0] w_m1, h_m1;
   logic          pix, cov, rel, has_res, at_lcol, at_lrow, last;
   px_type        entry;
   logic [AW-1:0] addr;

   logic          s1_valid_ff, s1_res_ff, s1_last_ff, s1_hz_ff;
   logic [CW-1:0] s1_x_ff, s1_y_ff;
   logic [3:0]    s1_mask_ff;  // top, bottom, left, right
   px_type        s1_entry_ff, s1_byp_a_ff, s1_byp_b_ff;
   logic [AW-1:0] s1_addr_ff;

   px_type        a_q, b_q, a_rd, b_rd;
   pcol_type      win_ff [2];
   pcol_type      ncol;
   pcol_type      wcol [3];
   logic [2:0]    rmask, cmask;
   logic          hole;

   always_comb begin
      w_m1    = cfg.width - RW'(1);
      h_m1    = cfg.height - RW'(1);
      pix     = (in_row_ff < cfg.height) && !flush;
      cov     = pix && covered;
      rel     = cov && depth_finite && (opacity > cfg.alpha) &&
                (depth_value > cfg.near) && (depth_value < cfg.far);
      entry   = '{cov: cov, rel: rel, depth: pix ? depth_value : '0};
      addr    = AW'(in_col_ff);
      has_res = (in_row_ff != '0) && !((in_row_ff == RW'(1)) && (in_col_ff == '0));
      at_lcol = ({1'b0, out_col_ff} == w_m1);
      at_lrow = ({1'b0, out_row_ff} == h_m1);
      last    = has_res && at_lcol && at_lrow;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart || (accept && last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if ({1'b0, in_col_ff} == w_m1) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (has_res) begin
            if (at_lcol) begin
               out_col_in = '0;
               out_row_in = out_row_ff + CW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff   <= has_res;
         s1_last_ff  <= last;
         s1_x_ff     <= out_col_ff;
         s1_y_ff     <= out_row_ff;
         s1_mask_ff  <= {out_row_ff != '0, !at_lrow, out_col_ff != '0, !at_lcol};
         s1_entry_ff <= entry;
         s1_addr_ff  <= addr;
         s1_hz_ff    <= s1_valid_ff && (s1_addr_ff == addr);
         s1_byp_a_ff <= s1_entry_ff;
         s1_byp_b_ff <= a_rd;
      end
   end

   // line store a holds the previous line, b the one before it
   dhmf_ram #(.WIDTH($bits(px_type)), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_addr_ff),
      .wdata (s1_entry_ff),
      .re    (accept),
      .raddr (addr),
      .rdata (a_q)
   );

   dhmf_ram #(.WIDTH($bits(px_type)), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_addr_ff),
      .wdata (a_rd),
      .re    (accept),
      .raddr (addr),
      .rdata (b_q)
   );

   always_comb begin
      a_rd    = s1_hz_ff ? s1_byp_a_ff : a_q;
      b_rd    = s1_hz_ff ? s1_byp_b_ff : b_q;
      ncol    = '{s1_entry_ff, a_rd, b_rd};
      wcol[0] = win_ff[0];
      wcol[1] = win_ff[1];
      wcol[2] = ncol;
      hole    = !win_ff[1][1].cov;
      rmask   = {s1_mask_ff[2], 1'b1, s1_mask_ff[3]};
      cmask   = {s1_mask_ff[0], 1'b1, s1_mask_ff[1]};
      push_item.pos_x = s1_x_ff;
      push_item.pos_y = s1_y_ff;
      push_item.last  = s1_last_ff;
      push_item.hole  = hole;
      for (int i = 0; i < 8; i++) begin
         push_item.keys[i] = '1;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1)) begin
               push_item.keys[(r * 3 + c) - ((r * 3 + c) > 4 ? 1 : 0)] =
                  (wcol[c][r].rel && hole && rmask[r] && cmask[c]) ?
                  {1'b0, wcol[c][r].depth} : '1;
            end
         end
      end
      push = s1_valid_ff && s1_res_ff;
      busy = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= ncol;
      end
   end

endmodule

// ===== src/dhmf_queue.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - window queue
// Short FIFO between the window front end and the median back end.
// ----------------------------------------------------------------------------
`include "depth_hole_median_fill_core_macros.svh"

module dhmf_queue import dhmf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  win_item_type   push_item,
   input  logic           pop,
   output logic           valid,
   output win_item_type   head,
   output logic [QCW-1:0] level
);

   win_item_type   mem_ff [Q_DEPTH];
   logic [QPW-1:0] wr_ff, rd_ff;
   logic [QCW-1:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + QPW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QPW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign valid = (cnt_ff != '0);
   assign head  = mem_ff[rd_ff];
   assign level = cnt_ff;

   `DHMF_ASSERT_NOW(a_q_no_overflow, push && !pop, cnt_ff != QCW'(Q_DEPTH), "queue overflow")
   `DHMF_ASSERT_NOW(a_q_no_underflow, pop, cnt_ff != '0, "queue underflow")
   `DHMF_ASSERT_NEXT(a_q_count_up, push && !pop, cnt_ff == $past(cnt_ff) + QCW'(1), "queue count")

endmodule

// ===== src/dhmf_back.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - median back end
// Sorts the eight masked neighbors, picks the median and range checks it.
// ----------------------------------------------------------------------------
`include "depth_hole_median_fill_core_macros.svh"

module dhmf_back import dhmf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_valid,
   input  win_item_type  q_item,
   output logic          pop,
   input  logic          out_ready,
   output logic          out_valid,
   output logic [CW-1:0] out_x,
   output logic [CW-1:0] out_y,
   output logic          out_hole,
   output logic [3:0]    out_cnt,
   output logic          out_fill_valid,
   output depth_type     out_fill,
   output logic          out_last
);

   logic        adv;
   logic        p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, o_v_ff;
   bk_item_type p1_ff, p2_ff, p3_ff, p4_ff, p1_in, p2_in, p3_in;
   depth_type   med_ff;
   logic [2:0]  hi_idx, lo_idx;
   logic [DEPTH_BITS:0] sum;
   logic          fv;

   logic [CW-1:0] o_x_ff, o_y_ff;
   logic          o_hole_ff, o_fv_ff, o_last_ff;
   logic [3:0]    o_cnt_ff;
   depth_type     o_fill_ff;

   assign adv = !o_v_ff || out_ready;
   assign pop = adv && q_valid;

   always_comb begin
      p1_in.pos_x = q_item.pos_x;
      p1_in.pos_y = q_item.pos_y;
      p1_in.last  = q_item.last;
      p1_in.hole  = q_item.hole;
      p1_in.cnt   = count_valid(q_item.keys);
      p1_in.keys  = sort_layer(sort_layer(q_item.keys, 3'd0), 3'd1);

      p2_in      = p1_ff;
      p2_in.keys = sort_layer(sort_layer(p1_ff.keys, 3'd2), 3'd3);
      p3_in      = p2_ff;
      p3_in.keys = sort_layer(sort_layer(p2_ff.keys, 3'd4), 3'd5);

      hi_idx = p3_ff.cnt[3:1];
      lo_idx = p3_ff.cnt[0] ? hi_idx : hi_idx - 3'd1;
      sum    = {1'b0, p3_ff.keys[lo_idx][DEPTH_BITS-1:0]} +
               {1'b0, p3_ff.keys[hi_idx][DEPTH_BITS-1:0]};

      fv = p4_ff.hole && (p4_ff.cnt >= 4'd2) &&
           (med_ff > cfg.near) && (med_ff < cfg.far);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= q_valid;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         o_v_ff  <= p4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         p3_ff      <= p3_in;
         p4_ff      <= p3_ff;
         med_ff     <= sum[DEPTH_BITS:1];
         o_x_ff     <= p4_ff.pos_x;
         o_y_ff     <= p4_ff.pos_y;
         o_hole_ff  <= p4_ff.hole;
         o_cnt_ff   <= p4_ff.cnt;
         o_fv_ff    <= fv;
         o_fill_ff  <= fv ? med_ff : '0;
         o_last_ff  <= p4_ff.last;
      end
   end

   assign out_valid      = o_v_ff;
   assign out_x          = o_x_ff;
   assign out_y          = o_y_ff;
   assign out_hole       = o_hole_ff;
   assign out_cnt        = o_cnt_ff;
   assign out_fill_valid = o_fv_ff;
   assign out_fill       = o_fill_ff;
   assign out_last       = o_last_ff;

   `DHMF_ASSERT_NOW(a_fill_needs_hole, o_v_ff && o_fv_ff, o_hole_ff && (o_cnt_ff >= 4'd2), "fill without hole")
   `DHMF_ASSERT_NOW(a_solid_no_count, o_v_ff && !o_hole_ff, o_cnt_ff == '0, "count on covered pixel")
   `DHMF_ASSERT_NOW(a_fill_zero, o_v_ff && !o_fv_ff, o_fill_ff == '0, "fill depth not cleared")

endmodule

// ===== src/depth_hole_median_fill_core.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - top level
// Masked 3x3 median fill of uncovered pixels in a streamed depth raster.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while req_tready is high, set by the line
//   stores taking one read and one write per port each cycle.
// Path: the word completing a pixel's window (one line plus one pixel later in
//   the stream) passes s1, the queue, p1 to p4 and the output register.
// Reset: synchronous; clears positions, pipeline and queue, loads register
//   defaults. Line stores are not cleared.
module depth_hole_median_fill_core import dhmf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,   // depth_value, depth_finite, opacity, covered
   input  logic             req_tuser,   // flush
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,   // pos_x, pos_y, is_hole, neighbor_count,
                                         // fill_valid, fill_depth
   output logic             rsp_tlast,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int WLIM = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;

   logic [RW-1:0] width_ff, height_ff;
   depth_type     near_ff, far_ff;
   logic [15:0]   alpha_ff;
   cfg_type       cfg;
   logic          restart, accept, busy, push, pop, q_valid;
   win_item_type  push_item, q_item;
   logic [QCW-1:0] q_level;

   logic [CW-1:0] o_x, o_y;
   logic          o_hole, o_fv;
   logic [3:0]    o_cnt;
   depth_type     o_fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         near_ff   <= RST_NEAR;
         far_ff    <= RST_FAR;
         alpha_ff  <= RST_ALPHA;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMG_WIDTH:  width_ff  <= csr_wdata[RW-1:0];
            REG_IMG_HEIGHT: height_ff <= csr_wdata[RW-1:0];
            REG_NEAR:       near_ff   <= csr_wdata[DEPTH_BITS-1:0];
            REG_FAR:        far_ff    <= csr_wdata[DEPTH_BITS-1:0];
            REG_ALPHA:      alpha_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.width  = (width_ff == '0) ? RW'(1) :
                   ((width_ff > RW'(WLIM)) ? RW'(WLIM) : width_ff);
      cfg.height = (height_ff == '0) ? RW'(1) :
                   ((height_ff > RW'(POS_LIMIT)) ? RW'(POS_LIMIT) : height_ff);
      cfg.near   = near_ff;
      cfg.far    = far_ff;
      cfg.alpha  = alpha_ff;
      restart    = csr_we && ((csr_addr == REG_IMG_WIDTH) || (csr_addr == REG_IMG_HEIGHT));
   end

   assign req_tready = (q_level + QCW'(busy)) < QCW'(Q_DEPTH);
   assign accept     = req_tvalid && req_tready;

   dhmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .restart      (restart),
      .accept       (accept),
      .depth_value  (req_tdata[31:0]),
      .depth_finite (req_tdata[32]),
      .opacity      (req_tdata[48:33]),
      .covered      (req_tdata[49]),
      .flush        (req_tuser),
      .push         (push),
      .push_item    (push_item),
      .busy         (busy)
   );

   dhmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .valid     (q_valid),
      .head      (q_item),
      .level     (q_level)
   );

   dhmf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .pop            (pop),
      .out_ready      (rsp_tready),
      .out_valid      (rsp_tvalid),
      .out_x          (o_x),
      .out_y          (o_y),
      .out_hole       (o_hole),
      .out_cnt        (o_cnt),
      .out_fill_valid (o_fv),
      .out_fill       (o_fill),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, o_fill, o_fv, o_cnt, o_hole, o_y, o_x};

endmodule

// ===== dv/depth_hole_median_fill_checker.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - stream checker
// Tracks register writes, predicts the hole report of every pixel from the
// accepted input words and compares each result word field by field.
// ----------------------------------------------------------------------------
module depth_hole_median_fill_checker import dhmf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [55:0]      req_tdata,
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [63:0]      rsp_tdata,
   input  logic             rsp_tlast,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               errors,
   output int               pending,
   output int               reports
);

   typedef struct packed {
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic        hole;
      logic [3:0]  cnt;
      logic        valid;
      logic [31:0] fill;
      logic        last;
   } hole_report_type;

   hole_report_type report_q[$];
   px_type          rows[3][POS_LIMIT];
   cfg_type         cfg;
   int              in_col, in_row, out_col, out_row;

   assign pending = report_q.size();

   function automatic int eff_w();
      int w;
      w = int'(cfg.width);
      if (w == 0) w = 1;
      if (w > POS_LIMIT) w = POS_LIMIT;
      return w;
   endfunction

   function automatic int eff_h();
      int h;
      h = int'(cfg.height);
      if (h == 0) h = 1;
      if (h > POS_LIMIT) h = POS_LIMIT;
      return h;
   endfunction

   task automatic take_pixel(logic [55:0] d, logic fl);
      int              w, h, n, cnt;
      px_type          e;
      logic [31:0]     vals[8];
      logic [31:0]     v, med;
      logic [32:0]     sum;
      hole_report_type r;
      int              j;
      w = eff_w();
      h = eff_h();
      n = in_row * w + in_col;
      if (in_row < h) begin
         e = '0;
         if (!fl) begin
            e.depth = d[31:0];
            e.cov   = d[49];
            e.rel   = d[49] && d[32] && d[48:33] > cfg.alpha &&
                      d[31:0] > cfg.near && d[31:0] < cfg.far;
         end
         rows[in_row % 3][in_col] = e;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (n < w + 1) return;
      r = '0;
      r.pos_x = out_col[11:0];
      r.pos_y = out_row[11:0];
      r.hole  = !rows[out_row % 3][out_col].cov;
      r.last  = (out_row == h - 1) && (out_col == w - 1);
      cnt = 0;
      if (r.hole) begin
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               if ((dx == 0 && dy == 0) || out_row + dy < 0 || out_row + dy >= h ||
                   out_col + dx < 0 || out_col + dx >= w) continue;
               e = rows[(out_row + dy) % 3][out_col + dx];
               if (e.rel) begin
                  vals[cnt] = e.depth;
                  cnt++;
               end
            end
         for (int i = 1; i < cnt; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > v) begin
               vals[j] = vals[j - 1];
               j--;
            end
            vals[j] = v;
         end
         if (cnt >= 2) begin
            if (cnt % 2) med = vals[cnt / 2];
            else begin
               sum = {1'b0, vals[cnt / 2 - 1]} + {1'b0, vals[cnt / 2]};
               med = sum[32:1];
            end
            if (med > cfg.near && med < cfg.far) begin
               r.valid = 1'b1;
               r.fill  = med;
            end
         end
      end
      r.cnt = cnt[3:0];
      report_q = {report_q, r};
      if (r.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   task automatic check_report(logic [63:0] d, logic lst);
      hole_report_type a, x;
      a = {d[11:0], d[23:12], d[24], d[28:25], d[29], d[61:30], lst};
      reports++;
      if (report_q.size() == 0) begin
         $display("%0t unexpected result word %h last %b", $time, d, lst);
         errors++;
         return;
      end
      x = report_q.pop_front();
      if (a.pos_x !== x.pos_x)
         $display("%0t pos_x exp %0d got %0d", $time, x.pos_x, a.pos_x);
      if (a.pos_y !== x.pos_y)
         $display("%0t pos_y exp %0d got %0d", $time, x.pos_y, a.pos_y);
      if (a.hole !== x.hole)
         $display("%0t is_hole exp %b got %b", $time, x.hole, a.hole);
      if (a.cnt !== x.cnt)
         $display("%0t neighbor_count exp %0d got %0d", $time, x.cnt, a.cnt);
      if (a.valid !== x.valid)
         $display("%0t fill_valid exp %b got %b", $time, x.valid, a.valid);
      if (a.fill !== x.fill)
         $display("%0t fill_depth exp %h got %h", $time, x.fill, a.fill);
      if (a.last !== x.last)
         $display("%0t frame_last exp %b got %b", $time, x.last, a.last);
      if (a !== x) errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg <= {RST_WIDTH, RST_HEIGHT, RST_NEAR, RST_FAR, RST_ALPHA};
         in_col <= 0; in_row <= 0; out_col <= 0; out_row <= 0;
         report_q.delete();
         errors <= 0;
         reports <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_IMG_WIDTH: begin
                  cfg.width = csr_wdata[RW-1:0];
                  in_col = 0; in_row = 0; out_col = 0; out_row = 0;
               end
               REG_IMG_HEIGHT: begin
                  cfg.height = csr_wdata[RW-1:0];
                  in_col = 0; in_row = 0; out_col = 0; out_row = 0;
               end
               REG_NEAR:  cfg.near  = csr_wdata;
               REG_FAR:   cfg.far   = csr_wdata;
               REG_ALPHA: cfg.alpha = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_report(rsp_tdata, rsp_tlast);
      end
   end

endmodule

// ===== dv/depth_hole_median_fill_core_tb.sv =====
// ----------------------------------------------------------------------------
// Depth hole median fill - testbench top
// Streams small and zero-size depth frames with drain words through the
// core under changing bounds and thresholds, with random gaps and stalls on
// both sides; the checker predicts and compares every hole report.
// ----------------------------------------------------------------------------
module depth_hole_median_fill_core_tb import dhmf_pkg::*;;

   localparam int STALL_LIMIT = 4000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [55:0]      req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [63:0]      rsp_tdata;
   logic             rsp_tlast;
   logic             csr_we = 1'b0;
   logic [2:0]       csr_addr = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   int          errors, pending, reports;
   int          pixels_sent, frames_run;
   bit          tx_calm, rx_calm, rx_hold;
   logic [31:0] near_q, far_q;
   logic [15:0] alpha_q;

   always #4 clock = ~clock;

   depth_hole_median_fill_core dut (.*);

   depth_hole_median_fill_checker chk (.*);

   task automatic csr_write(csr_idx_type idx, logic [31:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(logic [55:0] d, logic fl);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= fl;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] pick_depth();
      logic [63:0] span;
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return near_q;
         3: return far_q;
         4: return near_q + 1;
         5: return far_q - 1;
         default: begin
            span = {32'h0, far_q} - {32'h0, near_q};
            if (far_q <= near_q + 1 || span < 2) return $urandom;
            return near_q + 1 + 32'($urandom % (span - 1));
         end
      endcase
   endfunction

   // mode 0: random, 1: checkerboard holes among finite, fully opaque pixels
   function automatic logic [56:0] make_pixel(int mode, int x, int y);
      logic [31:0] d;
      logic [15:0] a;
      logic        fin, cov, fl;
      d = pick_depth();
      if (mode == 1) begin
         cov = 1'((x + y) % 2);
         fin = 1'b1;
         a   = 16'hFFFF;
         fl  = 1'b0;
      end else begin
         cov = $urandom_range(0, 9) < 6;
         fin = $urandom_range(0, 9) != 0;
         a   = $urandom_range(0, 3) == 0 ? 16'($urandom) :
               ($urandom_range(0, 1) ? 16'hFFFF : alpha_q + 16'd1);
         fl  = $urandom_range(0, 19) == 0;
      end
      return {fl, 6'h0, cov, a, fin, d};
   endfunction

   task automatic set_bounds(logic [31:0] nr, logic [31:0] fr, logic [15:0] al);
      near_q = nr; far_q = fr; alpha_q = al;
      csr_write(REG_NEAR, nr);
      csr_write(REG_FAR, fr);
      csr_write(REG_ALPHA, al);
   endtask

   task automatic run_frame(int wr, int hr, int mode);
      int          w, h, lim;
      logic [56:0] p;
      w = wr == 0 ? 1 : (wr > POS_LIMIT ? POS_LIMIT : wr);
      h = hr == 0 ? 1 : (hr > POS_LIMIT ? POS_LIMIT : hr);
      csr_write(REG_IMG_WIDTH, wr);
      csr_write(REG_IMG_HEIGHT, hr);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            p = make_pixel(mode, x, y);
            send_word(p[55:0], p[56]);
            pixels_sent++;
         end
      // drain words; some carry pixel data that must be ignored
      for (int i = 0; i <= w; i++) begin
         p = make_pixel(0, 0, 0);
         send_word(p[55:0], $urandom_range(0, 3) != 0);
      end
      req_tvalid <= 1'b0;
      lim = 0;
      while (pending != 0 && lim < 100000) begin
         @(posedge clock);
         lim++;
      end
      repeat (20) @(posedge clock);
      frames_run++;
   endtask

   always begin
      int gap;
      @(posedge clock);
      if (!reset) begin
         if (rx_hold) begin
            rx_tready_low: begin
               rsp_tready <= 1'b0;
               repeat (600) @(posedge clock);
               rx_hold = 1'b0;
            end
         end
         gap = rx_calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset ||
             csr_we || (pending == 0 && !req_tvalid))
            stall = 0;
         else
            stall++;
      end
      $display("stalled %0d cycles with %0d results outstanding", stall, pending);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      pixels_sent = 0;
      frames_run  = 0;
      tx_calm = 1'b0; rx_calm = 1'b0; rx_hold = 1'b0;
      near_q = RST_NEAR; far_q = RST_FAR; alpha_q = RST_ALPHA;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, dense holes, tiny frames, bound extremes
      run_frame(3, 3, 1);
      run_frame(4, 2, 1);
      run_frame(0, 0, 0);
      set_bounds(32'h0, 32'hFFFF_FFFF, 16'h0);
      run_frame(3, 3, 1);
      csr_write(csr_idx_type'(5), 32'h1);
      csr_write(csr_idx_type'(7), 32'hFFFF_FFFF);
      set_bounds(32'hFFFF_FFFF, 32'h0, 16'hFFFF);
      run_frame(2, 3, 0);

      // wider frame, no idling
      tx_calm = 1'b1; rx_calm = 1'b1;
      set_bounds(32'h0, 32'hFFFF_FFFF, 16'h0);
      run_frame(12, 2, 1);

      // long receiver hold-off while the sender keeps going
      tx_calm = 1'b1; rx_calm = 1'b0;
      rx_hold = 1'b1;
      run_frame(9, 9, 0);

      while (pixels_sent < 290) begin
         tx_calm = $urandom_range(0, 3) == 0;
         rx_calm = $urandom_range(0, 3) == 0;
         case ($urandom_range(0, 2))
            0: set_bounds(32'h0, 32'hFFFF_FFFF, 16'($urandom));
            1: set_bounds(RST_NEAR, RST_FAR, RST_ALPHA);
            default: set_bounds($urandom_range(0, 32'h7FFF_FFFF),
                                32'h8000_0000 | $urandom, 16'($urandom));
         endcase
         run_frame($urandom_range(1, 9), $urandom_range(1, 6), $urandom_range(0, 3) == 0);
      end

      $display("%0d frames, %0d pixels, %0d hole reports checked", frames_run,
               pixels_sent, reports);
      $display("sizes up to 12 wide and 9 high plus zero size, bound extremes, stalls both sides");
      if (errors == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/dhmf_pkg.sv
src/dhmf_ram.sv
src/dhmf_front.sv
src/dhmf_queue.sv
src/dhmf_back.sv
src/depth_hole_median_fill_core.sv
dv/depth_hole_median_fill_checker.sv
dv/depth_hole_median_fill_core_tb.sv
